### rtl/lca_pkg.sv
// Package for the Game of Life block: action codes, controller states,
// command struct and grid constants. No dependencies.
package lca_pkg;

  localparam int GRID_SIZE_DEFAULT = 32;
  localparam int ADDR_W = 5;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESULT
  } state_t;

  // controller to datapath; load_result marks every accepted beat
  typedef struct packed {
    logic load_result;
    logic do_set;
    logic do_step;
    logic do_read;
  } cmd_t;

endpackage

### rtl/lca_ctrl.sv
// Controller for the Game of Life block: input handshake, action decode,
// result handshake. Uses lca_pkg.
module lca_ctrl
  import lca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   accept;

  assign accept = in_valid && in_ready;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state: a new beat may enter as the previous result leaves
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready && !in_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // decode the accepted action; every accepted beat loads a result
  always_comb begin
    cmd = '0;
    if (accept) begin
      cmd.load_result = 1'b1;
      unique case (action_t'(action))
        ACT_SET:  cmd.do_set  = 1'b1;
        ACT_STEP: cmd.do_step = 1'b1;
        ACT_READ: cmd.do_read = 1'b1;
        ACT_NONE: cmd.do_read = 1'b0;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_set, cmd.do_step, cmd.do_read})) else $error("more than one command");
  a_cmd_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd != '0) |-> accept) else $error("command without accept");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid) else $error("no result after accept");

endmodule

### rtl/lca_grid.sv
// Datapath for the Game of Life block: the cell array with neighbor
// links and the read result register. Uses lca_pkg.
module lca_grid
  import lca_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  logic [ADDR_W-1:0] col,
  input  logic [ADDR_W-1:0] row,
  output logic              cell_alive
);

  logic [GRID_SIZE-1:0] cells [GRID_SIZE];
  logic [GRID_SIZE-1:0] cells_next [GRID_SIZE];
  logic                 in_grid;
  logic                 rd_bit;

  assign in_grid = (32'(col) < GRID_SIZE) && (32'(row) < GRID_SIZE);

  // pick the addressed cell
  always_comb begin
    rd_bit = 1'b0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        if (32'(row) == r && 32'(col) == c) rd_bit = cells[r][c];
      end
    end
  end

  // each cell counts its eight neighbors; off-grid counts dead
  always_comb begin
    logic [3:0] n;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        n = '0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_SIZE &&
                c + dc >= 0 && c + dc < GRID_SIZE) begin
              n = n + 4'(cells[r+dr][c+dc]);
            end
          end
        end
        cells_next[r][c] = (n == 4'd3) || (cells[r][c] && n == 4'd2);
      end
    end
  end

  // advance, set or hold the grid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_SIZE; r++) cells[r] <= '0;
    end else if (cmd.do_step) begin
      cells <= cells_next;
    end else if (cmd.do_set && in_grid) begin
      for (int r = 0; r < GRID_SIZE; r++) begin
        for (int c = 0; c < GRID_SIZE; c++) begin
          if (32'(row) == r && 32'(col) == c) cells[r][c] <= 1'b1;
        end
      end
    end
  end

  // register the result beat; cleared for every non-read beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_alive <= 1'b0;
    end else if (cmd.load_result) begin
      cell_alive <= cmd.do_read && in_grid && rd_bit;
    end
  end

endmodule

### rtl/life_cellular_automaton.sv
// Top level of the Game of Life block: controller plus cell array.
// Depends on lca_pkg, lca_ctrl and lca_grid.
//
// A GRID_SIZE x GRID_SIZE B3/S23 grid with dead borders, all dead after
// reset. Each input beat sets a cell, advances one generation, reads a cell
// or does nothing, and yields exactly one result beat in the next cycle. The
// cell array updates every cell at once, even for a full generation, and a
// new beat is taken each cycle while results are drained.
module life_cellular_automaton
  import lca_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [ADDR_W-1:0] col,
  input  logic [ADDR_W-1:0] row,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              cell_alive
);

  cmd_t cmd;

  lca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lca_grid #(.GRID_SIZE(GRID_SIZE)) u_grid (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .col        (col),
    .row        (row),
    .cell_alive (cell_alive)
  );

endmodule
